>>> rtl/pgb_pkg.sv
package pgb_pkg;

  // Printable character range held in the glyph store.
  localparam logic [7:0] FIRST_CODE = 8'h20;
  localparam logic [9:0] GLYPHS_PER_FONT = 10'd96;

  // Framebuffer geometry of one plane, in bytes.
  localparam logic [31:0] ROW_BYTES = 32'd80;
  localparam logic [31:0] PLANE_BYTES = 32'd38400;

  // Glyph store index width before it is fitted to the store depth.
  localparam int GIDX_W = 13;

  // Draw jobs waiting between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic ACTION_LOAD = 1'b0;
  localparam logic ACTION_DRAW = 1'b1;

  typedef struct packed {
    logic       action;
    logic [2:0] font_select;
    logic [7:0] char_code;
    logic [2:0] glyph_row;
    logic [7:0] row_bits;
    logic [9:0] pos_x;
    logic [8:0] pos_y;
    logic [3:0] color;
  } cmd_t;

  typedef struct packed {
    logic [31:0] byte_address;
    logic [7:0]  pixel_mask;
    logic [7:0]  write_bits;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [2:0] font;
    logic [6:0] glyph_off;
    logic [9:0] pos_x;
    logic [8:0] pos_y;
    logic [3:0] color;
  } job_t;

  typedef struct packed {
    logic q_full;
    logic q_empty;
    logic back_idle;
  } drain_t;

  // Byte index of one glyph row: eight rows per glyph, 96 glyphs per font.
  function automatic logic [GIDX_W-1:0] glyph_index(input logic [2:0] font,
                                                    input logic [6:0] off,
                                                    input logic [2:0] row);
    logic [9:0] num;
    num = 10'(font) * GLYPHS_PER_FONT + 10'(off);
    return {num, row};
  endfunction

endpackage

>>> rtl/pgb_ram.sv
module pgb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/pgb_queue.sv
module pgb_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  pgb_pkg::job_t push_job,
  input  logic         pop,
  output pgb_pkg::job_t pop_job,
  output logic         full,
  output logic         empty
);

  import pgb_pkg::*;

  job_t              entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] ptr);
    return (ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + QPTR_W'(1);
  endfunction

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign pop_job = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/pgb_front.sv
module pgb_front #(
  parameter int FONT_COUNT = 8,
  parameter int AW = 13
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  pgb_pkg::cmd_t   cmd,
  input  pgb_pkg::drain_t drain,
  output logic            busy,
  output logic            push,
  output pgb_pkg::job_t   push_job,
  output logic            ram_we,
  output logic [AW-1:0]   ram_waddr,
  output logic [7:0]      ram_wdata
);

  import pgb_pkg::*;

  localparam logic [4:0] FONTS = 5'(FONT_COUNT);

  logic          accept;
  logic          code_ok;
  logic          font_ok;
  logic          take_load;
  logic          drain_ok;
  logic          ld_valid;
  logic [AW-1:0] ld_addr;
  logic [7:0]    ld_data;
  logic [AW-1:0] in_addr;

  assign busy      = ld_valid || drain.q_full;
  assign accept    = start && !busy;
  // Printable means bit 7 clear and not in the control range below 0x20.
  assign code_ok   = !cmd.char_code[7] && (cmd.char_code[6:5] != 2'b00);
  assign font_ok   = 5'(cmd.font_select) < FONTS;
  assign take_load = accept && (cmd.action == ACTION_LOAD) && code_ok && font_ok;
  // The store may change only when no draw can still read it.
  assign drain_ok  = drain.q_empty && drain.back_idle;
  assign in_addr   = AW'(glyph_index(cmd.font_select, 7'(cmd.char_code - FIRST_CODE),
                                     cmd.glyph_row));

  assign push               = accept && (cmd.action == ACTION_DRAW) && code_ok;
  assign push_job.font      = font_ok ? cmd.font_select : 3'd0;
  assign push_job.glyph_off = 7'(cmd.char_code - FIRST_CODE);
  assign push_job.pos_x     = cmd.pos_x;
  assign push_job.pos_y     = cmd.pos_y;
  assign push_job.color     = cmd.color;

  always_comb begin
    if (ld_valid) begin
      ram_we    = drain_ok;
      ram_waddr = ld_addr;
      ram_wdata = ld_data;
    end else begin
      ram_we    = take_load && drain_ok;
      ram_waddr = in_addr;
      ram_wdata = cmd.row_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (take_load && !drain_ok) begin
      ld_addr <= in_addr;
      ld_data <= cmd.row_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ld_valid <= 1'b0;
    end else if (ld_valid) begin
      ld_valid <= !drain_ok;
    end else begin
      ld_valid <= take_load && !drain_ok;
    end
  end

endmodule

>>> rtl/pgb_back.sv
module pgb_back #(
  parameter int SCREEN_WIDTH = 640,
  parameter int SCREEN_HEIGHT = 480,
  parameter int AW = 13
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [31:0]     base,
  input  logic            q_empty,
  input  pgb_pkg::job_t   q_job,
  output logic            pop,
  output logic            idle,
  output logic            ram_re,
  output logic [AW-1:0]   ram_raddr,
  input  logic [7:0]      ram_rdata,
  output logic            result_strobe,
  output pgb_pkg::result_t result
);

  import pgb_pkg::*;

  localparam logic [10:0] SCREEN_W = 11'(SCREEN_WIDTH);
  localparam logic [9:0]  SCREEN_H = 10'(SCREEN_HEIGHT);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CALC,
    S_EMIT,
    S_FLUSH
  } state_t;

  state_t      state;
  job_t        job;
  logic [2:0]  row;
  logic [7:0]  lmask;
  logic [7:0]  rmask;
  logic [31:0] line_addr;
  logic        side;
  logic [1:0]  plane;
  result_t     pend;
  logic        pend_valid;

  logic [9:0]  y;
  logic [7:0]  col0;
  logic [15:0] spread;
  logic [7:0]  lmask_next;
  logic [7:0]  rmask_next;
  logic [31:0] line_addr_next;
  result_t     wr;
  result_t     flush_beat;
  logic [7:0]  wr_mask;
  logic        row_done;

  // On-screen bits of one framebuffer byte column, bit 7 leftmost.
  function automatic logic [7:0] clip_mask(input logic [7:0] colbyte);
    logic [7:0] m;
    for (int k = 0; k < 8; k++) begin
      m[7-k] = ({colbyte, 3'b000} + 11'(k)) < SCREEN_W;
    end
    return m;
  endfunction

  assign idle      = (state == S_IDLE);
  assign pop       = (state == S_IDLE) && !q_empty;
  assign ram_re    = (state == S_READ);
  assign ram_raddr = AW'(glyph_index(job.font, job.glyph_off, row));

  always_comb begin
    y      = 10'(job.pos_y) + 10'(row);
    col0   = 8'(job.pos_x[9:3]);
    spread = {ram_rdata, 8'h00} >> job.pos_x[2:0];
    if (y < SCREEN_H) begin
      lmask_next = spread[15:8] & clip_mask(col0);
      rmask_next = spread[7:0] & clip_mask(col0 + 8'd1);
    end else begin
      lmask_next = 8'h00;
      rmask_next = 8'h00;
    end
    line_addr_next = base + 32'(y) * ROW_BYTES + 32'(col0)
                     + 32'(lmask_next == 8'h00);
  end

  always_comb begin
    wr_mask         = side ? rmask : lmask;
    wr.byte_address = line_addr + 32'(plane) * PLANE_BYTES;
    wr.pixel_mask   = wr_mask;
    wr.write_bits   = job.color[plane] ? wr_mask : 8'h00;
    wr.last         = 1'b0;
    flush_beat      = pend;
    flush_beat.last = 1'b1;
    row_done        = (plane == 2'd3) && (side || (rmask == 8'h00));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      pend_valid    <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            job   <= q_job;
            row   <= 3'd0;
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_CALC;
        end
        S_CALC: begin
          lmask     <= lmask_next;
          rmask     <= rmask_next;
          line_addr <= line_addr_next;
          side      <= (lmask_next == 8'h00);
          plane     <= 2'd0;
          if ((lmask_next != 8'h00) || (rmask_next != 8'h00)) begin
            state <= S_EMIT;
          end else if (row == 3'd7) begin
            state <= S_FLUSH;
          end else begin
            row   <= row + 3'd1;
            state <= S_READ;
          end
        end
        S_EMIT: begin
          // Hold each write back by one so the final one can carry last.
          result_strobe <= pend_valid;
          result        <= pend;
          pend          <= wr;
          pend_valid    <= 1'b1;
          plane         <= plane + 2'd1;
          if (row_done) begin
            if (row == 3'd7) begin
              state <= S_FLUSH;
            end else begin
              row   <= row + 3'd1;
              state <= S_READ;
            end
          end else if (plane == 2'd3) begin
            side      <= 1'b1;
            line_addr <= line_addr + 32'd1;
          end
        end
        S_FLUSH: begin
          result_strobe <= pend_valid;
          result        <= flush_beat;
          pend_valid    <= 1'b0;
          state         <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/planar_glyph_blitter_unit.sv
// Planar glyph blitter. Load commands fill a glyph store of 8x8 bitmaps (96
// printable characters per font); draw commands turn one glyph into masked
// byte writes for a four-plane planar framebuffer whose plane 0 starts at
// back_buffer_base. A command is taken on a clock edge where start is high
// and busy is low. Every write beat is shown on result for exactly one cycle
// with result_strobe high, and the receiver cannot stall it, so the
// framebuffer side must take one beat per cycle. A load is written to the
// store at the edge that takes it, or, when a draw is still queued or
// running, in the first cycle the drawing engine is idle with nothing queued;
// busy stays high while such a load waits. Up to two draws queue in front of
// the drawing engine; busy is also high while that queue is full. For each
// glyph row the drawing engine does one glyph store read, then the shift,
// clip and address arithmetic, then emits that row's beats; it picks up a
// draw in its idle state and finishes it in its flush state, and a draw
// emits at most 64 beats. Each beat is held back one step until the next
// one proves it is not the last, so the beats of a row come out in
// consecutive cycles one step behind the engine, while the final beat of
// each row waits through the lookup cycles of the following rows. Draws of
// characters outside 0x20..0x7F and loads that name such a character or a
// font at or beyond FONT_COUNT are taken and dropped. A draw naming a font
// at or beyond FONT_COUNT uses font 0. Reading a glyph row that was never
// loaded gives undefined bits.
module planar_glyph_blitter_unit #(
  parameter int FONT_COUNT = 8,
  parameter int SCREEN_WIDTH = 640,
  parameter int SCREEN_HEIGHT = 480
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  pgb_pkg::cmd_t    cmd,
  input  logic             cfg_we,
  input  logic [31:0]      cfg_data,
  output logic             result_strobe,
  output pgb_pkg::result_t result
);

  import pgb_pkg::*;

  // One font is 96 glyphs of 8 rows, one byte per row.
  localparam int STORE_DEPTH = FONT_COUNT * 96 * 8;
  localparam int AW = $clog2(STORE_DEPTH);

  // The user must rewrite the framebuffer base only while idle; nothing enforces it.
  logic [31:0] back_buffer_base;

  logic          q_push;
  job_t          q_push_job;
  logic          q_pop;
  job_t          q_pop_job;
  logic          q_full;
  logic          q_empty;
  logic          back_idle;
  drain_t        drain;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      back_buffer_base <= 32'd0;
    end else if (cfg_we) begin
      back_buffer_base <= cfg_data;
    end
  end

  assign drain.q_full    = q_full;
  assign drain.q_empty   = q_empty;
  assign drain.back_idle = back_idle;

  // Front end: takes commands, performs loads, queues printable draws.
  pgb_front #(
    .FONT_COUNT (FONT_COUNT),
    .AW         (AW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .drain     (drain),
    .busy      (busy),
    .push      (q_push),
    .push_job  (q_push_job),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  pgb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_push_job),
    .pop      (q_pop),
    .pop_job  (q_pop_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Glyph store: written by the front end, read by the drawing engine.
  pgb_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Drawing engine: walks the eight glyph rows and emits the write beats.
  pgb_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .AW            (AW)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .base          (back_buffer_base),
    .q_empty       (q_empty),
    .q_job         (q_pop_job),
    .pop           (q_pop),
    .idle          (back_idle),
    .ram_re        (ram_re),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata),
    .result_strobe (result_strobe),
    .result        (result)
  );

  // The glyph store must never change under a draw that may still read it.
  a_store_write_safe: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (back_idle && q_empty))
    else $error("glyph store written while a draw is pending");

  // A beat always changes some bits and never sets bits outside its mask.
  a_beat_mask: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> ((result.pixel_mask != 8'h00) &&
                       ((result.write_bits & ~result.pixel_mask) == 8'h00)))
    else $error("write beat with empty mask or bits outside the mask");

  // The queue never takes a draw it has no room for.
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (!q_full || q_pop))
    else $error("draw queue overflow");

  // The final beat of a draw is shown while the engine is already idle.
  a_last_ends_draw: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && result.last) |-> back_idle)
    else $error("last beat while the drawing engine is still busy");

endmodule

>>> verif/planar_glyph_blitter_unit_tb.sv
`timescale 1ns / 100ps

// Self-checking bench for the planar glyph blitter. Glyph rows are loaded
// through the command port, and draws are issued only for glyphs whose eight
// rows have all been written. A scoreboard keeps its own glyph store and back
// buffer base. For every accepted command it works out the framebuffer write
// beats, then checks each strobed beat against the oldest one still waiting.
module planar_glyph_blitter_unit_tb;
  import pgb_pkg::*;

  localparam int FONTS = 8;
  localparam int SCR_W = 640;
  localparam int SCR_H = 480;
  localparam int GLYPHS = 96;
  localparam int GLYPH_SLOTS = FONTS * GLYPHS;
  localparam int STORE_DEPTH = GLYPH_SLOTS * 8;
  localparam logic [7:0] LAST_CODE = 8'h7F;

  // Worst case the engine holds two queued draws plus one running, each up
  // to 64 beats, and loads wait behind them; this covers that with margin.
  localparam int SETTLE_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int CMDS_PER_PHASE = 125;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  cmd_t    cmd = '0;
  logic    cfg_we = 1'b0;
  logic [31:0] cfg_data = '0;
  logic    result_strobe;
  result_t result;

  planar_glyph_blitter_unit #(
    .FONT_COUNT(FONTS),
    .SCREEN_WIDTH(SCR_W),
    .SCREEN_HEIGHT(SCR_H)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .result_strobe(result_strobe),
    .result(result)
  );

  // The scoreboard mirrors the block: a byte per glyph row and the current
  // back buffer base. Write beats are predicted in the order the block
  // emits them, so a plain FIFO is enough to match them.
  class glyph_blit_scoreboard;
    logic [31:0] base;
    logic [7:0]  glyph_mem [STORE_DEPTH];
    result_t     expected_q[$];
    int          mismatches;
    int          beats_checked;

    function new();
      base = '0;
      mismatches = 0;
      beats_checked = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function int unsigned slot(input logic [2:0] font, input logic [7:0] code,
                               input int unsigned row);
      return (int'(font) * GLYPHS + int'(code - FIRST_CODE)) * 8 + row;
    endfunction

    function void note_cmd(input cmd_t c);
      logic [2:0]  font;
      logic [7:0]  g;
      logic [7:0]  mask;
      logic [7:0]  onscreen;
      int unsigned sh;
      int unsigned y;
      int unsigned colbyte;
      int          count;
      result_t     w;
      // Codes outside the printable range neither load nor draw.
      if (c.char_code < FIRST_CODE || c.char_code > LAST_CODE) return;
      if (c.action == ACTION_LOAD) begin
        if (c.font_select < FONTS)
          glyph_mem[slot(c.font_select, c.char_code, c.glyph_row)] = c.row_bits;
        return;
      end
      // A font past the configured count falls back to the default font.
      font = (c.font_select < FONTS) ? c.font_select : 3'd0;
      sh = c.pos_x[2:0];
      count = 0;
      for (int row = 0; row < 8; row++) begin
        y = c.pos_y + row;
        g = glyph_mem[slot(font, c.char_code, row)];
        if (y >= SCR_H || g == 8'h00) continue;
        for (int side = 0; side < 2; side++) begin
          colbyte = c.pos_x[9:3] + side;
          if (side == 0) mask = g >> sh;
          else mask = (sh == 0) ? 8'h00 : 8'(g << (8 - sh));
          // Pixels past the right screen edge are cut from the mask.
          for (int k = 0; k < 8; k++) onscreen[7-k] = (colbyte * 8 + k < SCR_W);
          mask &= onscreen;
          if (mask == 8'h00) continue;
          for (int pl = 0; pl < 4; pl++) begin
            w.byte_address = base + pl * PLANE_BYTES + y * ROW_BYTES + colbyte;
            w.pixel_mask = mask;
            w.write_bits = c.color[pl] ? mask : 8'h00;
            w.last = 1'b0;
            expected_q.push_back(w);
            count++;
          end
        end
      end
      if (count > 0) begin
        w = expected_q.pop_back();
        w.last = 1'b1;
        expected_q.push_back(w);
      end
    endfunction

    function void report(input string what, input result_t want, input result_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s: expected addr=%h mask=%h bits=%h last=%b, %s",
                 $realtime, what, want.byte_address, want.pixel_mask, want.write_bits,
                 want.last,
                 $sformatf("got addr=%h mask=%h bits=%h last=%b",
                           got.byte_address, got.pixel_mask, got.write_bits, got.last));
    endfunction

    function void check_write(input result_t got);
      result_t want;
      beats_checked++;
      if (expected_q.size() == 0) begin
        report("write beat with nothing expected", '0, got);
        return;
      end
      want = expected_q.pop_front();
      if (got.byte_address !== want.byte_address || got.pixel_mask !== want.pixel_mask ||
          got.write_bits !== want.write_bits || got.last !== want.last)
        report("write beat mismatch", want, got);
    endfunction
  endclass

  glyph_blit_scoreboard blit_sb;

  // Which rows of each glyph have been written. Random printable draws only ever
  // pick glyphs from ready_q, so the bench never reads a store row that was not loaded.
  bit [7:0] rows_loaded [GLYPH_SLOTS];
  int       ready_q[$];

  int  cycle_count = 0;
  int  cmds_sent = 0;
  int  loads_sent = 0;
  int  draws_sent = 0;
  int  bases_used = 0;
  // When set, the sender keeps start high and offers a new command every cycle in which busy is low.
  bit  steady = 1'b0;

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d write beats outstanding.",
               cycle_count, blit_sb.pending());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Write beats cannot be stalled, so every strobe is taken and checked at
  // the edge that ends its cycle.
  always @(posedge clk) begin
    if (!rst && result_strobe) blit_sb.check_write(result);
  end

  // Sender tasks are entered and left at a falling edge.
  task automatic issue(input cmd_t c);
    int id;
    if (!steady) begin
      while ($urandom_range(0, 99) < 22) begin
        start <= 1'b0;
        @(negedge clk);
      end
    end
    start <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    blit_sb.note_cmd(c);
    cmds_sent++;
    if (c.char_code >= FIRST_CODE && c.char_code <= LAST_CODE) begin
      if (c.action == ACTION_DRAW) begin
        draws_sent++;
      end else begin
        loads_sent++;
        id = int'(c.font_select) * GLYPHS + int'(c.char_code - FIRST_CODE);
        if (rows_loaded[id] != 8'hFF) begin
          rows_loaded[id][c.glyph_row] = 1'b1;
          if (rows_loaded[id] == 8'hFF) ready_q.push_back(id);
        end
      end
    end
    @(negedge clk);
  endtask

  // Fields that a command does not use are left random.
  function automatic cmd_t noise_cmd();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(cmd_t)-1:0];
  endfunction

  task automatic load_glyph(input logic [2:0] font, input logic [7:0] code,
                            input logic [63:0] bitmap);
    cmd_t c;
    for (int r = 0; r < 8; r++) begin
      c = noise_cmd();
      c.action = ACTION_LOAD;
      c.font_select = font;
      c.char_code = code;
      c.glyph_row = 3'(r);
      c.row_bits = bitmap[63 - 8*r -: 8];
      issue(c);
    end
  endtask

  task automatic draw_char(input logic [2:0] font, input logic [7:0] code,
                           input logic [9:0] x, input logic [8:0] y, input logic [3:0] color);
    cmd_t c;
    c = noise_cmd();
    c.action = ACTION_DRAW;
    c.font_select = font;
    c.char_code = code;
    c.pos_x = x;
    c.pos_y = y;
    c.color = color;
    issue(c);
  endtask

  // Stops the sender until every predicted beat has come out, then lets the
  // engine finish any draws or loads that produce no beats.
  task automatic drain_and_rest();
    start <= 1'b0;
    while (blit_sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_base(input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    blit_sb.base = value;
    bases_used++;
  endtask

  // Positions lean toward the visible area, with a share hugging the right
  // and bottom edges so clipping gets plenty of traffic.
  function automatic logic [9:0] pick_x();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 10'($urandom_range(0, SCR_W - 1));
    if (r < 8) return 10'($urandom_range(SCR_W - 16, SCR_W + 15));
    return 10'($urandom_range(0, 1023));
  endfunction

  function automatic logic [8:0] pick_y();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 9'($urandom_range(0, SCR_H - 1));
    if (r < 8) return 9'($urandom_range(SCR_H - 16, SCR_H + 7));
    return 9'($urandom_range(0, 511));
  endfunction

  // Mostly whole glyph loads and draws of loaded glyphs with random content;
  // the rest are stray single-row loads and draws of unprintable codes.
  task automatic random_phase(input int target);
    int          counted;
    int          r;
    int          id;
    logic [63:0] bitmap;
    logic [7:0]  code;
    cmd_t        c;
    counted = 0;
    while (counted < target) begin
      r = $urandom_range(0, 99);
      if (r < 14 || ready_q.size() == 0) begin
        bitmap = '0;
        if ($urandom_range(0, 9) != 0)
          for (int k = 0; k < 8; k++)
            bitmap[63 - 8*k -: 8] = ($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom);
        load_glyph(3'($urandom_range(0, FONTS - 1)),
                   8'($urandom_range(FIRST_CODE, LAST_CODE)), bitmap);
        counted += 8;
      end else if (r < 20) begin
        c = noise_cmd();
        c.action = ACTION_LOAD;
        issue(c);
        if (c.char_code >= FIRST_CODE && c.char_code <= LAST_CODE) counted++;
      end else if (r < 25) begin
        code = $urandom_range(0, 1) ? 8'($urandom_range(0, FIRST_CODE - 1)) :
                                      8'($urandom_range(LAST_CODE + 1, 255));
        draw_char(3'($urandom_range(0, FONTS - 1)), code, pick_x(), pick_y(),
                  4'($urandom_range(0, 15)));
      end else begin
        id = ready_q[$urandom_range(0, ready_q.size() - 1)];
        draw_char(3'(id / GLYPHS), 8'(int'(FIRST_CODE) + id % GLYPHS), pick_x(), pick_y(),
                  4'($urandom_range(0, 15)));
        counted++;
      end
    end
  endtask

  initial begin
    cmd_t c;
    blit_sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    write_base(32'h0000_0000);

    // Directed part. The space glyph in the default font gets a mixed
    // pattern with one blank row; code 0x7F in the last font is solid, so
    // an unaligned draw of it produces the full 64 write beats.
    load_glyph(3'd0, FIRST_CODE, 64'h80_01_FF_00_81_3C_7E_55);
    load_glyph(3'd7, LAST_CODE, {8{8'hFF}});
    // Loads naming unprintable codes must leave the store alone.
    c = noise_cmd();
    c.action = ACTION_LOAD;
    c.char_code = FIRST_CODE - 8'd1;
    issue(c);
    c.char_code = LAST_CODE + 8'd1;
    issue(c);
    draw_char(3'd0, FIRST_CODE, 10'd0, 9'd0, 4'hF);
    draw_char(3'd7, LAST_CODE, 10'd3, 9'd5, 4'h5);
    // Clipped on the right and bottom at once.
    draw_char(3'd7, LAST_CODE, 10'd637, 9'd476, 4'hA);
    // Entirely off screen: no beats.
    draw_char(3'd0, FIRST_CODE, 10'd1023, 9'd511, 4'h0);
    // Byte aligned at the last column, so only left bytes come out.
    draw_char(3'd7, LAST_CODE, 10'd632, 9'd472, 4'h3);
    // Starts just past the right edge: every bit is clipped.
    draw_char(3'd0, FIRST_CODE, 10'd644, 9'd100, 4'h9);
    draw_char(3'd0, FIRST_CODE - 8'd1, 10'd8, 9'd8, 4'hF);
    draw_char(3'd7, 8'hFF, 10'd8, 9'd8, 4'hF);
    drain_and_rest();

    // Random phases, each under its own base. The top of the address space
    // and a base just below it make the plane addresses wrap. The second
    // phase runs the sender flat out as one long stretch with no gaps.
    write_base(32'hFFFF_FFFF);
    random_phase(CMDS_PER_PHASE);
    drain_and_rest();
    write_base($urandom);
    steady = 1'b1;
    random_phase(CMDS_PER_PHASE);
    drain_and_rest();
    steady = 1'b0;
    write_base(32'hFFFF_6A00);
    random_phase(CMDS_PER_PHASE);
    drain_and_rest();
    write_base($urandom);
    random_phase(CMDS_PER_PHASE);
    drain_and_rest();

    $display("Sent %0d commands (%0d printable row loads, %0d printable draws) over %0d bases.",
             cmds_sent, loads_sent, draws_sent, bases_used);
    $display("Checked %0d framebuffer write beats; %0d mismatches, %0d beats still owed.",
             blit_sb.beats_checked, blit_sb.mismatches, blit_sb.pending());
    if (blit_sb.mismatches == 0 && blit_sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
